>>> design/assert_macros.svh
// assertion macros used by the encoder serializer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is high
`define B64_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never hold outside reset
`define B64_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> design/b64le_pkg.sv
// shared types, constants and symbol lookup for the base64 line encoder
`timescale 1ns / 1ps

package b64le_pkg;

   localparam int JOB_CHARS = 5;
   localparam int JOB_CNT_W = 3;
   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = 1;
   localparam int Q_CNT_W   = 2;
   localparam int CSR_ADDR_W = 3;

   localparam logic [7:0] CHAR_PAD = 8'h3D;
   localparam logic [7:0] CHAR_NL  = 8'h0A;
   localparam logic [7:0] GPL_RESET = 8'd16;

   localparam logic REG_GROUPS_PER_LINE = 1'b0;

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   typedef struct packed {
      logic [JOB_CNT_W-1:0]           count;
      logic [JOB_CHARS-1:0][7:0]      chars;
   } job_type;

   function automatic logic [7:0] sym(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26)
         sym = w + 8'd65;
      else if (v < 6'd52)
         sym = w + 8'd71;
      else if (v < 6'd62)
         sym = w - 8'd4;
      else if (v == 6'd62)
         sym = 8'h2B;
      else
         sym = 8'h2F;
   endfunction

endpackage

>>> design/b64le_front.sv
// front end: takes bytes, tracks group and line position, builds character jobs
`timescale 1ns / 1ps

module b64le_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] data_byte
   input  logic                 req_tlast,   // final_byte
   input  logic [7:0]           groups_per_line,
   output b64le_pkg::job_type   job,
   output logic                 job_valid,
   input  logic                 job_ready
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;
   logic [7:0] lgc_ff, lgc_in;
   logic       accept;
   logic       line_full;
   logic [7:0] b;

   assign req_tready = job_ready;
   assign job_valid  = req_tvalid;
   assign accept     = req_tvalid && job_ready;
   assign b          = req_tdata;

   assign line_full = ({1'b0, lgc_ff} + 9'd1) >= {1'b0, groups_per_line};

   always_comb begin
      job.chars = '0;
      job.count = '0;
      phase_in  = phase_ff;
      carry_in  = carry_ff;
      lgc_in    = lgc_ff;
      case (phase_ff)
         b64le_pkg::PHASE_SECOND: begin
            job.chars[0] = b64le_pkg::sym({carry_ff[1:0], b[7:4]});
            if (req_tlast) begin
               job.chars[1] = b64le_pkg::sym({b[3:0], 2'b00});
               job.chars[2] = b64le_pkg::CHAR_PAD;
               job.chars[3] = b64le_pkg::CHAR_NL;
               job.count    = 3'd4;
            end else begin
               job.count = 3'd1;
               carry_in  = b[3:0];
               phase_in  = b64le_pkg::PHASE_THIRD;
            end
         end
         b64le_pkg::PHASE_THIRD: begin
            job.chars[0] = b64le_pkg::sym({carry_ff, b[7:6]});
            job.chars[1] = b64le_pkg::sym(b[5:0]);
            if (req_tlast || line_full) begin
               job.chars[2] = b64le_pkg::CHAR_NL;
               job.count    = 3'd3;
               lgc_in       = '0;
            end else begin
               job.count = 3'd2;
               lgc_in    = lgc_ff + 8'd1;
            end
            carry_in = '0;
            phase_in = b64le_pkg::PHASE_FIRST;
         end
         default: begin
            // unused phase code behaves as the first byte of a group
            job.chars[0] = b64le_pkg::sym(b[7:2]);
            if (req_tlast) begin
               job.chars[1] = b64le_pkg::sym({b[1:0], 4'b0000});
               job.chars[2] = b64le_pkg::CHAR_PAD;
               job.chars[3] = b64le_pkg::CHAR_PAD;
               job.chars[4] = b64le_pkg::CHAR_NL;
               job.count    = 3'd5;
            end else begin
               job.count = 3'd1;
               carry_in  = {2'b00, b[1:0]};
               phase_in  = b64le_pkg::PHASE_SECOND;
            end
         end
      endcase
      if (req_tlast) begin
         phase_in = b64le_pkg::PHASE_FIRST;
         carry_in = '0;
         lgc_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64le_pkg::PHASE_FIRST;
         carry_ff <= '0;
         lgc_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
         lgc_ff   <= lgc_in;
      end
   end

endmodule

>>> design/b64le_queue.sv
// two-entry job queue between front end and serializer
`timescale 1ns / 1ps

module b64le_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  b64le_pkg::job_type   push_job,
   input  logic                 push_valid,
   output logic                 push_ready,
   output b64le_pkg::job_type   pop_job,
   output logic                 pop_valid,
   input  logic                 pop
);

   b64le_pkg::job_type mem_ff [b64le_pkg::Q_DEPTH];
   logic [b64le_pkg::Q_PTR_W-1:0] wptr_ff, rptr_ff;
   logic [b64le_pkg::Q_CNT_W-1:0] cnt_ff, cnt_in;
   logic push_en, pop_en;

   assign push_ready = cnt_ff != b64le_pkg::Q_CNT_W'(b64le_pkg::Q_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_job    = mem_ff[rptr_ff];
   assign push_en    = push_valid && push_ready;
   assign pop_en     = pop && pop_valid;

   always_comb begin
      cnt_in = cnt_ff;
      if (push_en && !pop_en)
         cnt_in = cnt_ff + 1'b1;
      else if (pop_en && !push_en)
         cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push_en)
         mem_ff[wptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (push_en)
            wptr_ff <= wptr_ff + 1'b1;
         if (pop_en)
            rptr_ff <= rptr_ff + 1'b1;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> design/b64le_back.sv
// serializer: sends job characters one per cycle unless rsp stalls
`timescale 1ns / 1ps

`include "assert_macros.svh"

module b64le_back (
   input  logic                 clock,
   input  logic                 reset,
   input  b64le_pkg::job_type   job,
   input  logic                 job_valid,
   output logic                 job_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [7:0] out_char
   output logic                 rsp_tlast    // run_end
);

   logic [b64le_pkg::JOB_CNT_W-1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       load;
   logic       is_last;

   assign load    = job_valid && (!valid_ff || rsp_tready);
   assign is_last = idx_ff == (job.count - 1'b1);
   assign job_pop = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = is_last ? '0 : idx_ff + 1'b1;
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= job.chars[idx_ff];
         last_ff <= is_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = last_ff;

   `B64_ASSERT(a_job_count, clock, reset, job_valid |-> (job.count >= 3'd1 && job.count <= 3'd5), "job with bad character count")
   `B64_ASSERT(a_idx_range, clock, reset, job_valid |-> (idx_ff < job.count), "character index past end of job")
   `B64_ASSERT_NEVER(a_idx_idle, clock, reset, !job_valid && idx_ff != '0, "index not cleared with queue empty")

endmodule

>>> design/base64_line_encoder_unit.sv
// top level of the base64 encoder with line wrap
`timescale 1ns / 1ps

// Base64 encoder with line wrap.
// req channel: one raw byte per word in req_tdata, req_tlast marks the last
// byte of a stream. rsp channel: one ASCII character per word in rsp_tdata
// (symbol, '=' pad or newline), rsp_tlast on the last character caused by a
// byte. Each byte yields 1 to 5 characters; every stream ends with a newline.
// csr port: register 0 (addresses 0 to 3) is groups_per_line, four-character
// groups per line, reset value 16; write it only while the block is idle.
// The first character of a byte is stored in the job queue and then loaded
// into the output register before it is valid on rsp. The output register
// sends one character per cycle while rsp_tready is high, and a two-entry
// job queue lets the input run ahead of the output. Reset clears group
// position, line count and queue and loads the register default. When the
// receiver stalls, the current character holds in the output register, the
// queue fills and req_tready drops.

module base64_line_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic        rsp_tlast,   // run_end
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [b64le_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0] gpl_ff;
   logic       reg_hit;
   b64le_pkg::job_type front_job, head_job;
   logic front_valid, q_ready, head_valid, head_pop;

   assign csr_pready = 1'b1;
   assign reg_hit = csr_paddr[b64le_pkg::CSR_ADDR_W-1] == b64le_pkg::REG_GROUPS_PER_LINE;
   assign csr_prdata = reg_hit ? {24'd0, gpl_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset)
         gpl_ff <= b64le_pkg::GPL_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_hit)
         gpl_ff <= csr_pwdata[7:0];
   end

   b64le_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .groups_per_line (gpl_ff),
      .job             (front_job),
      .job_valid       (front_valid),
      .job_ready       (q_ready)
   );

   b64le_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_job   (front_job),
      .push_valid (front_valid),
      .push_ready (q_ready),
      .pop_job    (head_job),
      .pop_valid  (head_valid),
      .pop        (head_pop)
   );

   b64le_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job        (head_job),
      .job_valid  (head_valid),
      .job_pop    (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
